>>> hw/rtl/sdspi_pkg.sv
// Package for the SD card SPI-mode host engine.
// Opcodes, status codes, config register indices and block constants.
package sdspi_pkg;

    localparam int BLOCK_BYTES         = 512;
    localparam int POWERUP_CLOCK_BYTES = 10;
    localparam int BC_W                = 10;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_XCHG  = 2'd3;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_INIT_OK   = 3'd1;
    localparam logic [2:0] ST_PWR_FAIL  = 3'd2;
    localparam logic [2:0] ST_IFC_FAIL  = 3'd3;
    localparam logic [2:0] ST_ECHO_FAIL = 3'd4;
    localparam logic [2:0] ST_RDY_TMO   = 3'd5;
    localparam logic [2:0] ST_NOT_RDY   = 3'd6;
    localparam logic [2:0] ST_XFER_DONE = 3'd7;

    localparam logic [2:0] REG_IDLE_RETRY  = 3'd0;
    localparam logic [2:0] REG_READY_RETRY = 3'd1;
    localparam logic [2:0] REG_RESP_POLL   = 3'd2;
    localparam logic [2:0] REG_READ_WAIT   = 3'd3;
    localparam logic [2:0] REG_WRITE_WAIT  = 3'd4;
    localparam logic [2:0] REG_RETRY_GAP   = 3'd5;

endpackage

>>> hw/rtl/sd_spi_host_engine_core.sv
// SD card SPI-mode host engine, top level.
// Uses sdspi_pkg. Single module: config registers, sequencer, result register.
//
// Input channel (in_valid/in_stall): opcode selects init, read, write, or
// the report of a finished byte exchange with rx_byte. Output channel
// (out_valid/out_stall): one result beat per input beat, giving the next
// byte to send, chip select, and data/write-request/done flags.
// The sequencer updates the state and loads the result register on the
// edge that accepts the input beat. Throughput is one beat per cycle
// while not stalled; in_stall rises only when the result register is full
// and the receiver stalls, so a stalled result holds and no input is taken.
// Reset clears the sequencer to idle, loads register defaults (10, 100, 8,
// 1563, 3907, 1250) and empties the result register.
// Configuration: APB-style, registers at byte address 4*i. The user must write
// them only while the engine is idle; the block itself does not enforce this.
module sd_spi_host_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] block_addr,
    input  logic [7:0]  write_byte,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        chip_select,
    output logic        exchange_wanted,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        write_data_wanted,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [7:0]  r1_value,
    output logic [7:0]  token,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdspi_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PWR, PH_PRE0, PH_PRE1, PH_CMD, PH_R1, PH_R7, PH_POST0,
        PH_POST1, PH_GAP, PH_RTOK, PH_RDATA, PH_RCRC0, PH_RCRC1, PH_WSTART,
        PH_WDATA, PH_WRESP, PH_WBUSY
    } phase_t;

    typedef enum logic [2:0] {
        K_CMD0, K_CMD8, K_CMD58, K_CMD55, K_ACMD41, K_CMD17, K_CMD24
    } cmd_t;

    logic [7:0]  idle_lim_reg, ready_lim_reg, resp_lim_reg;
    logic [15:0] rd_lim_reg, wr_lim_reg, gap_reg;

    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [BC_W-1:0] bc_reg, bc_next;
    logic [15:0] att_reg, att_next, poll_reg, poll_next;
    logic [31:0] resp_reg, resp_next, addr_reg, addr_next;
    logic [7:0]  r1_reg, r1_next, tok_reg, tok_next, lr1_reg, lr1_next;

    logic [7:0]  o_tx;
    logic        o_cs, o_ex, o_dv, o_wd, o_done;
    logic [2:0]  o_st;

    logic        ov_reg;
    logic [7:0]  tx_reg, db_reg;
    logic        cs_reg, ex_reg, dv_reg, wd_reg, done_reg;
    logic [2:0]  st_reg;

    logic        in_fire, cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = ov_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        case (cfg_idx)
            REG_IDLE_RETRY:  prdata = {24'd0, idle_lim_reg};
            REG_READY_RETRY: prdata = {24'd0, ready_lim_reg};
            REG_RESP_POLL:   prdata = {24'd0, resp_lim_reg};
            REG_READ_WAIT:   prdata = {16'd0, rd_lim_reg};
            REG_WRITE_WAIT:  prdata = {16'd0, wr_lim_reg};
            REG_RETRY_GAP:   prdata = {16'd0, gap_reg};
            default:         prdata = 32'd0;
        endcase
    end

    function automatic logic [7:0] cmd_byte(cmd_t k, logic [BC_W-1:0] i,
                                            logic [31:0] a);
        logic [31:0] arg;
        logic [7:0]  idx, crc;
        begin
            unique case (k)
                K_CMD0:   begin idx = 8'd0;  crc = 8'h94; arg = 32'h0; end
                K_CMD8:   begin idx = 8'd8;  crc = 8'h86; arg = 32'h1AA; end
                K_CMD58:  begin idx = 8'd58; crc = 8'h00; arg = 32'h0; end
                K_CMD55:  begin idx = 8'd55; crc = 8'h00; arg = 32'h0; end
                K_ACMD41: begin idx = 8'd41; crc = 8'h00; arg = 32'h40000000; end
                K_CMD17:  begin idx = 8'd17; crc = 8'h00; arg = a; end
                K_CMD24:  begin idx = 8'd24; crc = 8'h00; arg = a; end
                default:  begin idx = 8'd0;  crc = 8'h00; arg = 32'h0; end
            endcase
            case (i)
                BC_W'(0): cmd_byte = 8'h40 | idx;
                BC_W'(1): cmd_byte = arg[31:24];
                BC_W'(2): cmd_byte = arg[23:16];
                BC_W'(3): cmd_byte = arg[15:8];
                BC_W'(4): cmd_byte = arg[7:0];
                default:  cmd_byte = crc | 8'h01;
            endcase
        end
    endfunction

    always_comb
    begin
        logic [15:0] pinc;
        logic [7:0]  r;
        logic        do_r1, r1_ovf;
        phase_next = phase_reg; cmd_next = cmd_reg; bc_next = bc_reg;
        att_next = att_reg; poll_next = poll_reg; resp_next = resp_reg;
        addr_next = addr_reg; r1_next = r1_reg; tok_next = tok_reg;
        lr1_next = lr1_reg;
        o_tx = 8'hFF; o_cs = 1'b0; o_ex = 1'b0; o_dv = 1'b0; o_wd = 1'b0;
        o_done = 1'b0; o_st = ST_BUSY;
        pinc = poll_reg + 16'd1;
        do_r1 = 1'b0; r = rx_byte; r1_ovf = 1'b0;

        if (opcode == OP_INIT) begin
            att_next = '0; bc_next = BC_W'(1);
            phase_next = PH_PWR; o_ex = 1'b1;
        end else if (opcode == OP_READ || opcode == OP_WRITE) begin
            addr_next = block_addr; r1_next = 8'hFF; tok_next = 8'hFF;
            cmd_next = (opcode == OP_READ) ? K_CMD17 : K_CMD24;
            phase_next = PH_PRE0; o_ex = 1'b1;
        end else if (phase_reg != PH_IDLE) begin
            unique case (phase_reg)
                PH_PWR: begin
                    o_ex = 1'b1;
                    if (bc_reg < BC_W'(POWERUP_CLOCK_BYTES)) bc_next = bc_reg + 1'b1;
                    else begin cmd_next = K_CMD0; phase_next = PH_PRE0; end
                end
                PH_PRE0: begin o_ex = 1'b1; o_cs = 1'b1; phase_next = PH_PRE1; end
                PH_PRE1: begin
                    o_ex = 1'b1; o_cs = 1'b1; bc_next = '0; phase_next = PH_CMD;
                    o_tx = cmd_byte(cmd_reg, '0, addr_reg);
                end
                PH_CMD: begin
                    o_ex = 1'b1; o_cs = 1'b1; bc_next = bc_reg + 1'b1;
                    if (bc_reg + 1'b1 < BC_W'(6))
                        o_tx = cmd_byte(cmd_reg, bc_reg + 1'b1, addr_reg);
                    else begin poll_next = '0; phase_next = PH_R1; end
                end
                PH_R1: begin
                    if (rx_byte != 8'hFF) do_r1 = 1'b1;
                    else begin
                        poll_next = pinc;
                        if (pinc > {8'd0, resp_lim_reg}) begin
                            do_r1 = 1'b1; r1_ovf = 1'b1;
                        end else begin o_ex = 1'b1; o_cs = 1'b1; end
                    end
                end
                PH_R7: begin
                    resp_next = {resp_reg[23:0], rx_byte};
                    bc_next = bc_reg + 1'b1; o_ex = 1'b1; o_cs = 1'b1;
                    if (!(bc_reg + 1'b1 < BC_W'(4))) phase_next = PH_POST0;
                end
                PH_POST0: begin o_ex = 1'b1; phase_next = PH_POST1; end
                PH_POST1: begin
                    unique case (cmd_reg)
                        K_CMD0: begin
                            if (lr1_reg != 8'd1) begin
                                att_next = att_reg + 16'd1;
                                if (att_reg + 16'd1 > {8'd0, idle_lim_reg}) begin
                                    phase_next = PH_IDLE; o_done = 1'b1;
                                    o_st = ST_PWR_FAIL;
                                end else begin
                                    cmd_next = K_CMD0; phase_next = PH_PRE0; o_ex = 1'b1;
                                end
                            end else begin
                                cmd_next = K_CMD8; phase_next = PH_PRE0; o_ex = 1'b1;
                            end
                        end
                        K_CMD8: begin
                            if (lr1_reg != 8'd1) begin
                                phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_IFC_FAIL;
                            end else if (resp_reg[7:0] != 8'hAA) begin
                                phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_ECHO_FAIL;
                            end else begin
                                att_next = '0;
                                cmd_next = K_CMD55; phase_next = PH_PRE0; o_ex = 1'b1;
                            end
                        end
                        K_CMD55, K_ACMD41: begin
                            if (cmd_reg == K_CMD55 && lr1_reg < 8'd2) begin
                                cmd_next = K_ACMD41; phase_next = PH_PRE0; o_ex = 1'b1;
                            end else if (gap_reg != 16'd0) begin
                                poll_next = 16'd1; phase_next = PH_GAP; o_ex = 1'b1;
                            end else begin
                                att_next = att_reg + 16'd1;
                                if (lr1_reg == 8'd0) begin
                                    cmd_next = K_CMD58; phase_next = PH_PRE0; o_ex = 1'b1;
                                end else if (att_reg + 16'd1 > {8'd0, ready_lim_reg}) begin
                                    phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_RDY_TMO;
                                end else begin
                                    cmd_next = K_CMD55; phase_next = PH_PRE0; o_ex = 1'b1;
                                end
                            end
                        end
                        K_CMD58: begin
                            phase_next = PH_IDLE; o_done = 1'b1;
                            o_st = resp_reg[31] ? ST_INIT_OK : ST_NOT_RDY;
                        end
                        default: begin
                            phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_XFER_DONE;
                        end
                    endcase
                end
                PH_GAP: begin
                    if (poll_reg < gap_reg) begin
                        poll_next = pinc; o_ex = 1'b1;
                    end else begin
                        att_next = att_reg + 16'd1;
                        if (lr1_reg == 8'd0) begin
                            cmd_next = K_CMD58; phase_next = PH_PRE0; o_ex = 1'b1;
                        end else if (att_reg + 16'd1 > {8'd0, ready_lim_reg}) begin
                            phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_RDY_TMO;
                        end else begin
                            cmd_next = K_CMD55; phase_next = PH_PRE0; o_ex = 1'b1;
                        end
                    end
                end
                PH_RTOK: begin
                    o_ex = 1'b1; o_cs = 1'b1;
                    if (rx_byte == 8'hFF) begin
                        poll_next = pinc;
                        if (pinc == rd_lim_reg) begin
                            tok_next = 8'hFF; phase_next = PH_POST0;
                        end
                    end else if (rx_byte == 8'hFE) begin
                        bc_next = '0; phase_next = PH_RDATA;
                    end else begin
                        tok_next = rx_byte; phase_next = PH_POST0;
                    end
                end
                PH_RDATA: begin
                    o_dv = 1'b1; o_ex = 1'b1; o_cs = 1'b1;
                    if (bc_reg >= BC_W'(BLOCK_BYTES - 1)) phase_next = PH_RCRC0;
                    else bc_next = bc_reg + 1'b1;
                end
                PH_RCRC0: begin o_ex = 1'b1; o_cs = 1'b1; phase_next = PH_RCRC1; end
                PH_RCRC1: begin
                    tok_next = 8'hFE; o_ex = 1'b1; o_cs = 1'b1; phase_next = PH_POST0;
                end
                PH_WSTART: begin
                    bc_next = '0; o_ex = 1'b1; o_cs = 1'b1; o_tx = write_byte;
                    phase_next = PH_WDATA; o_wd = (BLOCK_BYTES > 1);
                end
                PH_WDATA: begin
                    o_ex = 1'b1; o_cs = 1'b1;
                    if (bc_reg < BC_W'(BLOCK_BYTES - 1)) begin
                        bc_next = bc_reg + 1'b1; o_tx = write_byte;
                        o_wd = (bc_reg + 1'b1 < BC_W'(BLOCK_BYTES - 1));
                    end else begin
                        poll_next = 16'd1;
                        phase_next = (wr_lim_reg == 16'd1) ? PH_POST0 : PH_WRESP;
                    end
                end
                PH_WRESP: begin
                    o_ex = 1'b1; o_cs = 1'b1;
                    if (rx_byte == 8'hFF) begin
                        poll_next = pinc;
                        if (pinc == wr_lim_reg) phase_next = PH_POST0;
                    end else if (rx_byte[4:0] == 5'h05) begin
                        tok_next = 8'h05; poll_next = '0; phase_next = PH_WBUSY;
                    end else phase_next = PH_POST0;
                end
                PH_WBUSY: begin
                    o_ex = 1'b1; o_cs = 1'b1;
                    if (rx_byte != 8'd0) phase_next = PH_POST0;
                    else begin
                        poll_next = pinc;
                        if (pinc == wr_lim_reg) begin
                            tok_next = 8'h00; phase_next = PH_POST0;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase

            if (do_r1) begin
                if (r1_ovf) r = 8'hFF;
                lr1_next = r;
                o_ex = 1'b1; o_cs = 1'b1; phase_next = PH_POST0;
                case (cmd_reg)
                    K_CMD8, K_CMD58: begin
                        resp_next = '0;
                        if (r <= 8'd1) begin bc_next = '0; phase_next = PH_R7; end
                    end
                    K_CMD17: begin
                        r1_next = r;
                        if (r != 8'hFF) begin
                            poll_next = 16'd1;
                            if (rd_lim_reg == 16'd1) tok_next = 8'hFF;
                            else phase_next = PH_RTOK;
                        end
                    end
                    K_CMD24: begin
                        r1_next = r;
                        if (r == 8'd0) begin
                            phase_next = PH_WSTART; o_tx = 8'hFE; o_wd = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!o_ex) begin o_tx = 8'hFF; o_cs = 1'b0; end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idle_lim_reg <= 8'd10; ready_lim_reg <= 8'd100; resp_lim_reg <= 8'd8;
            rd_lim_reg <= 16'd1563; wr_lim_reg <= 16'd3907; gap_reg <= 16'd1250;
            phase_reg <= PH_IDLE; cmd_reg <= K_CMD0; bc_reg <= '0;
            att_reg <= '0; poll_reg <= '0; resp_reg <= '0; addr_reg <= '0;
            r1_reg <= 8'hFF; tok_reg <= 8'hFF; lr1_reg <= 8'hFF;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_IDLE_RETRY:  idle_lim_reg  <= pwdata[7:0];
                    REG_READY_RETRY: ready_lim_reg <= pwdata[7:0];
                    REG_RESP_POLL:   resp_lim_reg  <= pwdata[7:0];
                    REG_READ_WAIT:   rd_lim_reg    <= pwdata[15:0];
                    REG_WRITE_WAIT:  wr_lim_reg    <= pwdata[15:0];
                    REG_RETRY_GAP:   gap_reg       <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                phase_reg <= phase_next; cmd_reg <= cmd_next; bc_reg <= bc_next;
                att_reg <= att_next; poll_reg <= poll_next; resp_reg <= resp_next;
                addr_reg <= addr_next; r1_reg <= r1_next; tok_reg <= tok_next;
                lr1_reg <= lr1_next;
                ov_reg <= 1'b1;
            end else if (!out_stall) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            tx_reg <= o_tx; cs_reg <= o_cs; ex_reg <= o_ex;
            db_reg <= o_dv ? rx_byte : 8'd0; dv_reg <= o_dv; wd_reg <= o_wd;
            done_reg <= o_done; st_reg <= o_done ? o_st : ST_BUSY;
        end
    end

    assign out_valid         = ov_reg;
    assign tx_byte           = tx_reg;
    assign chip_select       = cs_reg;
    assign exchange_wanted   = ex_reg;
    assign data_byte         = db_reg;
    assign data_valid        = dv_reg;
    assign write_data_wanted = wd_reg;
    assign done_res          = done_reg;
    assign status            = st_reg;
    assign r1_value          = r1_reg;
    assign token             = tok_reg;

endmodule

>>> hw/rtl/sdspi_checker.sv
// Port-level checker for the SD SPI host engine, with its bind.
// Uses sdspi_pkg; watches only the top-level ports.
module sdspi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] tx_byte,
    input logic       chip_select,
    input logic       exchange_wanted,
    input logic       data_valid,
    input logic [7:0] data_byte,
    input logic       done_res,
    input logic [2:0] status
);
    import sdspi_pkg::*;

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted beat gave no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(tx_byte)))
        else $error("stalled result changed");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !exchange_wanted) |-> (tx_byte == 8'hFF && !chip_select))
        else $error("no exchange but bus fields set");

    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!exchange_wanted && status != ST_BUSY))
        else $error("done with exchange or busy status");

    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_valid) |-> (data_byte == 8'd0))
        else $error("data byte without flag");

endmodule

bind sd_spi_host_engine_core sdspi_checker u_sdspi_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .tx_byte(tx_byte),
    .chip_select(chip_select), .exchange_wanted(exchange_wanted),
    .data_valid(data_valid), .data_byte(data_byte), .done_res(done_res),
    .status(status)
);
